// File: sv/npcs_pkg.sv
// Shared constants, types and helpers of the nearest palette color search block.
package npcs_pkg;

  localparam int PALETTE_DEPTH = 576;
  localparam int IDX_W = 10;
  localparam int LEN_W = 10;
  localparam int COLOR_W = 8;
  localparam int DIST_W = 10;
  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int ENTRY_W = 3 * COLOR_W;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(576);
  localparam logic [DIST_W-1:0] DELTA_START = DIST_W'(1000);

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } npcs_state_e;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: sv/npcs_if.sv
// Handshake channel interfaces for requests, results and configuration.
interface npcs_req_if
  import npcs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [IDX_W-1:0]     entry_index;
  logic [COLOR_W-1:0]   red;
  logic [COLOR_W-1:0]   green;
  logic [COLOR_W-1:0]   blue;

  modport source (output valid, req_type, entry_index, red, green, blue, input ready);
  modport sink (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if
  import npcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] best_index;

  modport source (output valid, best_index, input ready);
  modport sink (input valid, best_index, output ready);
endinterface

interface npcs_cfg_if
  import npcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] palette_length;

  modport source (output valid, palette_length, input ready);
  modport sink (input valid, palette_length, output ready);
endinterface

// File: sv/nearest_palette_color_search_top.sv
// Nearest palette color search: palette memory, scan sequencer and shared distance unit.
// A write word stores one palette entry; it gives no result word.
// A query word scans the palette from entry 0 through one memory read port, one entry per
// cycle, and one shared distance-and-compare unit keeps the best entry; an exact match ends
// the scan early. The block takes no new word while a query is being scanned; a finished
// result waits in an output register while the next word is accepted. Entries must be
// written before a query scans them.
module nearest_palette_color_search_top
  import npcs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  npcs_req_if.sink   req_i,
  npcs_rsp_if.source rsp_o,
  npcs_cfg_if.sink   cfg_i
);

  logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

  npcs_state_e        state_q, state_d;
  logic [LEN_W-1:0]   pal_len_q;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   rd_addr_q, rd_addr_d;
  logic [ADDR_W-1:0]  rd_idx_q;
  logic               rd_vld_q, rd_vld_d;
  logic [ENTRY_W-1:0] rd_data_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic [DIST_W-1:0]  best_q, best_d;
  logic [ADDR_W-1:0]  best_idx_q, best_idx_d;
  logic               out_vld_q, out_vld_d;
  logic [IDX_W-1:0]   out_idx_q;

  logic               req_acc;
  logic               query_acc;
  logic               issue;
  logic               found;
  logic               scan_done;
  logic               out_load;
  logic [DIST_W-1:0]  l1_sum;

  assign req_acc   = req_i.valid && req_i.ready;
  assign query_acc = req_acc && (req_i.req_type == REQ_QUERY);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (int'(pal_len_q) > PALETTE_DEPTH) begin
      len_d = CNT_W'(PALETTE_DEPTH);
    end else begin
      len_d = CNT_W'(pal_len_q);
    end
  end

  assign l1_sum = DIST_W'(abs_diff(red_q, rd_data_q[3*COLOR_W-1:2*COLOR_W]))
                + DIST_W'(abs_diff(green_q, rd_data_q[2*COLOR_W-1:COLOR_W]))
                + DIST_W'(abs_diff(blue_q, rd_data_q[COLOR_W-1:0]));
  assign found = rd_vld_q && (l1_sum == '0);
  assign scan_done = found || (!rd_vld_q && (rd_addr_q == len_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    issue       = (state_q == ST_SCAN) && (rd_addr_q != len_q) && !found;
    out_load    = (state_q == ST_FINISH) && (!out_vld_q || rsp_o.ready);
  end

  always_comb begin
    rd_addr_d  = rd_addr_q;
    rd_vld_d   = issue;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (query_acc) begin
      rd_addr_d  = '0;
      best_d     = DELTA_START;
      best_idx_d = '0;
    end else begin
      if (issue) begin
        rd_addr_d = rd_addr_q + CNT_W'(1);
      end
      if (rd_vld_q && (l1_sum < best_q)) begin
        best_d     = l1_sum;
        best_idx_d = rd_idx_q;
      end
    end
    out_vld_d = out_vld_q;
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pal_len_q <= LEN_RESET;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        pal_len_q <= cfg_i.palette_length;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    if (query_acc) begin
      len_q   <= len_d;
      red_q   <= req_i.red;
      green_q <= req_i.green;
      blue_q  <= req_i.blue;
    end
    if (issue) begin
      rd_idx_q <= rd_addr_q[ADDR_W-1:0];
    end
    if (out_load) begin
      out_idx_q <= IDX_W'(best_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && (req_i.req_type == REQ_WRITE)
        && (int'(req_i.entry_index) < PALETTE_DEPTH)) begin
      mem[ADDR_W'(req_i.entry_index)] <= {req_i.red, req_i.green, req_i.blue};
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr_q[ADDR_W-1:0]];
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.best_index = out_idx_q;

endmodule

// File: sv/npcs_checker.sv
// Port-level assertions for the nearest palette color search block and their bind.
module npcs_checker
  import npcs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             req_type_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [IDX_W-1:0] best_index_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Result word dropped before it was taken.");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(best_index_i))
    else $error("Stalled result word changed.");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_type_i == REQ_QUERY) |=> !req_ready_i)
    else $error("New word accepted while a query is scanned.");

  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_type_i == REQ_WRITE) |=> req_ready_i)
    else $error("Palette write did not complete in one cycle.");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (int'(best_index_i) < PALETTE_DEPTH))
    else $error("Result index beyond the palette.");

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .best_index_i (rsp_o.best_index)
);

// File: dv/nearest_palette_color_search_top_tb.sv
// Self-checking testbench for the nearest palette color search block.
`timescale 1ns / 100ps

module nearest_palette_color_search_top_tb;
  import npcs_pkg::*;

  localparam int HOLDOFF_CYCLES = 300;
  localparam int IDLE_CYCLES = 8;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  typedef struct packed {
    req_type_e            kind;
    logic [IDX_W-1:0]     idx;
    logic [ENTRY_W-1:0]   rgb;
  } pal_word_t;

  logic clk = 1'b0;
  logic rst_n;

  npcs_req_if req_if ();
  npcs_rsp_if rsp_if ();
  npcs_cfg_if cfg_if ();

  nearest_palette_color_search_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state, updated as words are accepted.
  logic [ENTRY_W-1:0] color_table [PALETTE_DEPTH];
  int unsigned        scan_length;
  logic [IDX_W-1:0]   exp_best_idx [$];

  // Planning state of the stimulus, updated as words are queued.
  logic [ENTRY_W-1:0] plan_rgb [PALETTE_DEPTH];
  bit                 plan_set [PALETTE_DEPTH];
  pal_word_t          pending_words [$];

  pal_word_t   drv_word;
  int unsigned burst_left, gap_left;
  logic [7:0]  stall_pat;
  int unsigned pat_age;
  int unsigned holdoff_asks, holdoff_done, holdoff_left;

  int unsigned n_errors, n_results, n_writes, n_ignored, n_queries;
  int unsigned n_exact, n_ties, n_lengths, n_in_stalls;

  function automatic int unsigned chan_dist(input logic [COLOR_W-1:0] a,
                                            input logic [COLOR_W-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic logic [IDX_W-1:0] nearest_entry(input logic [ENTRY_W-1:0] rgb);
    int unsigned lim, l1_sum, best_dist;
    logic [IDX_W-1:0] best;
    lim = (scan_length > PALETTE_DEPTH) ? PALETTE_DEPTH : scan_length;
    best_dist = DELTA_START;
    best = '0;
    for (int unsigned i = 0; i < lim && best_dist != 0; i++) begin
      l1_sum = chan_dist(rgb[23:16], color_table[i][23:16])
             + chan_dist(rgb[15:8], color_table[i][15:8])
             + chan_dist(rgb[7:0], color_table[i][7:0]);
      if (l1_sum < best_dist) begin
        best_dist = l1_sum;
        best = IDX_W'(i);
      end else if (l1_sum == best_dist) begin
        n_ties++;
      end
    end
    if (best_dist == 0) n_exact++;
    return best;
  endfunction

  function automatic void absorb_word(input pal_word_t w);
    if (w.kind == REQ_WRITE) begin
      n_writes++;
      if (w.idx < PALETTE_DEPTH) color_table[w.idx] = w.rgb;
      else n_ignored++;
    end else begin
      n_queries++;
      exp_best_idx.push_back(nearest_entry(w.rgb));
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) absorb_word(drv_word);
      if (req_if.valid && !req_if.ready) n_in_stalls++;
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          drv_word = pending_words.pop_front();
          req_if.req_type    <= drv_word.kind;
          req_if.entry_index <= drv_word.idx;
          req_if.red         <= drv_word.rgb[23:16];
          req_if.green       <= drv_word.rgb[15:8];
          req_if.blue        <= drv_word.rgb[7:0];
          req_if.valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and requested by the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
      holdoff_done <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_done != holdoff_asks) begin
      holdoff_done <= holdoff_asks;
      holdoff_left <= HOLDOFF_CYCLES;
    end
  end

  // Receiver and result checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_pat = 8'hFF;
      pat_age = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (exp_best_idx.size() == 0) begin
          n_errors++;
          $display("%0t: result word with no query pending, expected none, actual %0d",
                   $time, rsp_if.best_index);
        end else if (rsp_if.best_index !== exp_best_idx[0]) begin
          n_errors++;
          $display("%0t: best_index mismatch, expected %0d, actual %0d",
                   $time, exp_best_idx[0], rsp_if.best_index);
          void'(exp_best_idx.pop_front());
        end else begin
          void'(exp_best_idx.pop_front());
        end
      end
      if (pat_age == 0) begin
        pat_age = $urandom_range(20, 150);
        case ($urandom_range(0, 3))
          0, 1: stall_pat = 8'hFF;
          default: stall_pat = 8'($urandom);
        endcase
      end else begin
        pat_age--;
      end
      rsp_if.ready <= (holdoff_left == 0) && stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  function automatic logic [ENTRY_W-1:0] pick_color();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
      default: return ENTRY_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(input req_type_e kind, input logic [IDX_W-1:0] idx,
                            input logic [ENTRY_W-1:0] rgb);
    pal_word_t w;
    w.kind = kind;
    w.idx = idx;
    w.rgb = rgb;
    if (kind == REQ_WRITE && idx < PALETTE_DEPTH) begin
      plan_rgb[idx] = rgb;
      plan_set[idx] = 1'b1;
    end
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || req_if.valid || exp_best_idx.size() != 0);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_palette_length(input logic [LEN_W-1:0] len);
    wait_idle();
    cfg_if.palette_length <= len;
    cfg_if.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    scan_length = len;
    n_lengths++;
  endtask

  task automatic run_phase(input int unsigned len, input int unsigned budget,
                           input bit holdoff);
    int unsigned lim, gap, done, nq, sel, k, j;
    logic [ENTRY_W-1:0] rgb;
    set_palette_length(LEN_W'(len));
    if (holdoff) holdoff_asks <= holdoff_asks + 1;
    lim = (len > PALETTE_DEPTH) ? PALETTE_DEPTH : len;
    done = 0;
    nq = 0;
    while (done < budget || nq < 8) begin
      gap = 0;
      while (gap < lim && plan_set[gap]) gap++;
      sel = $urandom_range(0, 99);
      if (gap < lim && sel < 85) begin
        queue_word(REQ_WRITE, IDX_W'(gap), pick_color());
        done++;
      end else if (gap >= lim && sel < 50) begin
        k = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
        case ($urandom_range(0, 6))
          0, 1, 2: rgb = (lim == 0) ? pick_color() : plan_rgb[k];
          3: rgb = (lim == 0) ? pick_color() : plan_rgb[k] ^ ENTRY_W'($urandom & 32'h030303);
          default: rgb = pick_color();
        endcase
        queue_word(REQ_QUERY, IDX_W'($urandom_range(0, IDX_MAX)), rgb);
        done++;
        nq++;
      end else if (sel < 90) begin
        k = (lim == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, PALETTE_DEPTH - 1)
                                                     : $urandom_range(0, lim - 1);
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(0, k);
          rgb = plan_set[j] ? plan_rgb[j] : pick_color();
        end else begin
          rgb = pick_color();
        end
        queue_word(REQ_WRITE, IDX_W'(k), rgb);
        done++;
      end else begin
        queue_word(REQ_WRITE, IDX_W'($urandom_range(PALETTE_DEPTH, IDX_MAX)), pick_color());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_WRITE;
    req_if.entry_index = '0;
    req_if.red = '0;
    req_if.green = '0;
    req_if.blue = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.palette_length = '0;
    holdoff_asks = 0;
    scan_length = LEN_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed words: empty search, single entry, exact hits, ties and ignored writes.
    set_palette_length(LEN_W'(0));
    queue_word(REQ_QUERY, IDX_W'(IDX_MAX), 24'h123456);
    queue_word(REQ_WRITE, IDX_W'(0), 24'h000000);
    queue_word(REQ_WRITE, IDX_W'(1), 24'hFFFFFF);
    queue_word(REQ_WRITE, IDX_W'(2), 24'h808080);
    queue_word(REQ_WRITE, IDX_W'(3), 24'h000000);
    queue_word(REQ_WRITE, IDX_W'(4), 24'hFF0000);
    queue_word(REQ_WRITE, IDX_W'(IDX_MAX), 24'hFFFFFF);
    queue_word(REQ_WRITE, IDX_W'(PALETTE_DEPTH), 24'hFFFFFF);
    queue_word(REQ_WRITE, IDX_W'(PALETTE_DEPTH - 1), 24'h00FF00);
    set_palette_length(LEN_W'(1));
    queue_word(REQ_QUERY, IDX_W'(0), 24'hFFFFFF);
    set_palette_length(LEN_W'(5));
    queue_word(REQ_QUERY, IDX_W'(IDX_MAX), 24'h000000);
    queue_word(REQ_QUERY, IDX_W'(0), 24'hFFFFFF);
    queue_word(REQ_QUERY, IDX_W'(IDX_MAX), 24'h808080);
    queue_word(REQ_QUERY, IDX_W'(0), 24'h010101);
    queue_word(REQ_QUERY, IDX_W'(IDX_MAX), 24'h404040);
    queue_word(REQ_QUERY, IDX_W'(0), 24'hFF0000);
    queue_word(REQ_QUERY, IDX_W'(IDX_MAX), 24'hFE0101);
    queue_word(REQ_QUERY, IDX_W'(0), 24'h7F7F7F);
    queue_word(REQ_QUERY, IDX_W'(IDX_MAX), 24'h00FF00);

    run_phase(1, 40, 1'b0);
    run_phase(2, 40, 1'b0);
    run_phase(5, 40, 1'b0);
    run_phase(16, 40, 1'b0);
    run_phase(48, 40, 1'b0);
    run_phase(128, 20, 1'b0);
    run_phase(300, 20, 1'b0);
    run_phase(PALETTE_DEPTH, 20, 1'b0);
    run_phase(IDX_MAX, 30, 1'b0);
    run_phase(PALETTE_DEPTH + 1, 20, 1'b0);
    run_phase(7, 60, 1'b1);
    run_phase(0, 20, 1'b0);
    run_phase(3, 50, 1'b1);
    run_phase($urandom_range(1, 64), 50, 1'b0);
    run_phase(24, 50, 1'b0);
    run_phase($urandom_range(0, IDX_MAX), 20, 1'b0);
    wait_idle();

    $display("Covered %0d write words (%0d outside the palette) and %0d queries over %0d lengths.",
             n_writes, n_ignored, n_queries, n_lengths);
    $display("Checked %0d results: %0d exact matches, %0d ties, %0d stalled input cycles.",
             n_results, n_exact, n_ties, n_in_stalls);
    if (n_errors == 0) begin
      $display("nearest_palette_color_search_top_tb: done, clean");
    end else begin
      $display("nearest_palette_color_search_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d words queued and %0d results outstanding.",
             pending_words.size(), exp_best_idx.size());
    $display("nearest_palette_color_search_top_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
sv/npcs_pkg.sv
sv/npcs_if.sv
sv/nearest_palette_color_search_top.sv
sv/npcs_checker.sv
dv/nearest_palette_color_search_top_tb.sv
